// ===== rtl/point_in_polygon_test_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon test block
// Both expect signals named clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PIP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pip assertion failed");

// Next-cycle implication, disabled while in reset
`define PIP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pip assertion failed");

`endif

// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Types and constants shared by the point-in-polygon test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

	localparam int COORD_W          = 16;
	localparam int CMD_W            = 2;
	localparam int VCNT_W           = 7;
	localparam int MAX_VERTICES_DEF = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEST   = 2'd2
	} pip_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT
	} pip_state_t;

	typedef struct packed {
		pip_cmd_t                   cmd;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
	} pip_req_t;

	typedef struct packed {
		logic               inside_res;
		logic               status;
		logic [VCNT_W-1:0]  vertex_count;
	} pip_rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} pip_vertex_t;

	// Edge handed to the crossing unit
	typedef struct packed {
		logic vld;
		logic last;
	} pip_edge_tag_t;

	// Crossing unit verdict for one edge
	typedef struct packed {
		logic vld;
		logic last;
		logic tog;
	} pip_edge_res_t;

endpackage

// ===== rtl/point_in_polygon_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Even-odd point-in-polygon test over a store of signed integer vertices.
// ----------------------------------------------------------------------------
// Clear, append and unused commands finish without a walk: the result strobe
// done rises the cycle after start is taken and busy stays low. A test over
// N held vertices keeps busy high until its result is given; the vertex
// store has one read port and the walk reads one vertex per cycle, the
// closing vertex first, then vertices zero to N-1, followed by the store's
// read register and the crossing-unit stages. A test with no vertices
// answers like a clear, with busy low. Results cannot be held off: sample rsp
// whenever done is high. An append to a full store is dropped and reported
// with status set.
`timescale 1ns / 1ps
`include "point_in_polygon_test_top_macros.svh"

module point_in_polygon_test_top #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pip_pkg::pip_req_t req,
	output logic              done,
	output pip_pkg::pip_rsp_t rsp
);
	import pip_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	pip_vertex_t   wr_data, rd_data, vj;
	pip_edge_tag_t ein;
	pip_edge_res_t eout;
	logic signed [COORD_W-1:0] px, py;

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.ein     (ein),
		.vj      (vj),
		.px      (px),
		.py      (py),
		.eout    (eout)
	);

	pip_ram #(
		.WIDTH ($bits(pip_vertex_t)),
		.DEPTH (MAX_VERTICES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pip_edge_unit u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ein    (ein),
		.vi     (rd_data),
		.vj     (vj),
		.px     (px),
		.py     (py),
		.eout   (eout)
	);

	`PIP_ASSERT_IMP(a_no_write_in_walk, wr_en, !busy)
	`PIP_ASSERT_IMP(a_read_only_in_walk, rd_en, busy)
	`PIP_ASSERT_IMP(a_done_when_idle, done, !busy)
	`PIP_ASSERT_NXT(a_last_edge_gives_result, eout.vld && eout.last, done && !rsp.status)

endmodule

// ===== rtl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]          wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared crossing unit: one edge per cycle, differences, products, compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_edge_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pip_pkg::pip_edge_tag_t             ein,
	input  pip_pkg::pip_vertex_t               vi,
	input  pip_pkg::pip_vertex_t               vj,
	input  logic signed [pip_pkg::COORD_W-1:0] px,
	input  logic signed [pip_pkg::COORD_W-1:0] py,
	output pip_pkg::pip_edge_res_t             eout
);
	import pip_pkg::*;

	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] dpx_c, dy_c, dxe_c, dpy_c;
	logic                 cross_c;

	logic signed [DW-1:0] dpx_s2, dy_s2, dxe_s2, dpy_s2;
	logic                 cross_s2, vld_s2, last_s2;

	logic signed [PW-1:0] lhs_s3, rhs_s3;
	logic                 dyneg_s3, cross_s3, vld_s3, last_s3;
	logic                 left_c;

	always_comb begin
		dpx_c   = DW'(px) - DW'(vi.x);
		dy_c    = DW'(vj.y) - DW'(vi.y);
		dxe_c   = DW'(vj.x) - DW'(vi.x);
		dpy_c   = DW'(py) - DW'(vi.y);
		cross_c = (vi.y > py) != (vj.y > py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= ein.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dpx_s2   <= dpx_c;
		dy_s2    <= dy_c;
		dxe_s2   <= dxe_c;
		dpy_s2   <= dpy_c;
		cross_s2 <= cross_c;
		last_s2  <= ein.last;

		lhs_s3   <= PW'(dpx_s2) * PW'(dy_s2);
		rhs_s3   <= PW'(dxe_s2) * PW'(dpy_s2);
		dyneg_s3 <= dy_s2[DW-1];
		cross_s3 <= cross_s2;
		last_s3  <= last_s2;
	end

	// flip the compare when the edge runs downwards
	assign left_c = dyneg_s3 ? (lhs_s3 > rhs_s3) : (lhs_s3 < rhs_s3);

	assign eout.vld  = vld_s3;
	assign eout.last = last_s3;
	assign eout.tog  = cross_s3 & left_c;

endmodule

// ===== rtl/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: command decode, vertex count, store walk and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_ctrl #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  pip_pkg::pip_req_t                     req,
	output logic                                  done,
	output pip_pkg::pip_rsp_t                     rsp,
	output logic                                  wr_en,
	output logic [$clog2(MAX_VERTICES)-1:0]       wr_addr,
	output pip_pkg::pip_vertex_t                  wr_data,
	output logic                                  rd_en,
	output logic [$clog2(MAX_VERTICES)-1:0]       rd_addr,
	input  pip_pkg::pip_vertex_t                  rd_data,
	output pip_pkg::pip_edge_tag_t                ein,
	output pip_pkg::pip_vertex_t                  vj,
	output logic signed [pip_pkg::COORD_W-1:0]    px,
	output logic signed [pip_pkg::COORD_W-1:0]    py,
	input  pip_pkg::pip_edge_res_t                eout
);
	import pip_pkg::*;

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);

	pip_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] rd_addr_q, last_idx;
	logic          rd_first_q, rd_last;
	logic          rd_vld_s1, rd_prime_s1, rd_last_s1;
	logic          inside_q, done_q;
	logic          accept, has_room, status_d, imm_done, fin;
	pip_vertex_t   prev_q;
	pip_rsp_t      rsp_q;
	logic signed [COORD_W-1:0] px_q, py_q;

	assign accept   = start && (state_q == ST_IDLE);
	assign has_room = cnt_q < CW'(MAX_VERTICES);
	assign last_idx = AW'(cnt_q - CW'(1));
	assign fin      = eout.vld && eout.last;

	always_comb begin
		cnt_d    = cnt_q;
		status_d = 1'b0;
		imm_done = 1'b1;
		wr_en    = 1'b0;
		unique case (req.cmd)
			CMD_CLEAR: begin
				cnt_d = '0;
			end
			CMD_APPEND: begin
				if (has_room) begin
					cnt_d = cnt_q + CW'(1);
					wr_en = accept;
				end else begin
					status_d = 1'b1;
				end
			end
			CMD_TEST: begin
				imm_done = (cnt_q == '0);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !imm_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				rd_last = !rd_first_q && (rd_addr_q == last_idx);
				if (rd_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			rd_first_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_prime_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			done_q      <= (accept && imm_done) || fin;
			rd_vld_s1   <= rd_en;
			rd_prime_s1 <= rd_en && rd_first_q;
			rd_last_s1  <= rd_last;
			if (accept) begin
				cnt_q      <= cnt_d;
				rd_first_q <= 1'b1;
				inside_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_first_q <= 1'b0;
				end
				if (eout.vld && eout.tog) begin
					inside_q <= !inside_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q      <= req.coord_x;
			py_q      <= req.coord_y;
			rd_addr_q <= last_idx;
		end else if (rd_en) begin
			// the closing edge comes first, then walk from vertex zero upwards
			rd_addr_q <= rd_first_q ? '0 : rd_addr_q + AW'(1);
		end
		if (rd_vld_s1) begin
			prev_q <= rd_data;
		end
		if (accept) begin
			rsp_q.inside_res   <= 1'b0;
			rsp_q.status       <= status_d;
			rsp_q.vertex_count <= VCNT_W'(cnt_d);
		end else if (fin) begin
			rsp_q.inside_res   <= inside_q ^ eout.tog;
			rsp_q.status       <= 1'b0;
			rsp_q.vertex_count <= VCNT_W'(cnt_q);
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign rsp          = rsp_q;
	assign wr_addr      = cnt_q[AW-1:0];
	assign wr_data.x    = req.coord_x;
	assign wr_data.y    = req.coord_y;
	assign rd_addr      = rd_addr_q;
	assign ein.vld      = rd_vld_s1 && !rd_prime_s1;
	assign ein.last     = rd_last_s1;
	assign vj           = prev_q;
	assign px           = px_q;
	assign py           = py_q;

endmodule
